>>> hw/rtl/mdsg_pkg.sv
package mdsg_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned AXES_DEFAULT      = 3;
  localparam int unsigned TICK_BITS_DEFAULT = 20;

  // Fixed field widths.
  localparam int unsigned MOD_W  = 31;
  localparam int unsigned INC_W  = 31;
  localparam int unsigned ACC_W  = 33;
  localparam int unsigned MASK_W = 3;

  // Request codes carried in tuser.
  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;
  localparam logic KIND_LINE   = 1'b0;
  localparam logic KIND_DWELL  = 1'b1;

  // Per-tick control from the top level to every axis.
  typedef struct packed {
    logic do_tick;
    logic do_line_load;
  } mdsg_axis_ctl_t;

endpackage

>>> hw/rtl/mdsg_axis.sv
module mdsg_axis
  import mdsg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  mdsg_axis_ctl_t       ctl,
  input  logic [MOD_W-1:0]     modulus,
  input  logic [INC_W-1:0]     load_inc,
  input  logic                 load_fwd,
  output logic                 step,
  output logic                 dir_next
);

  logic [INC_W-1:0] inc;
  logic [ACC_W-1:0] acc;
  logic             dir;

  logic [ACC_W-1:0] acc_next;
  logic [INC_W-1:0] inc_next;
  logic [ACC_W-1:0] sum;
  logic [ACC_W-1:0] mod_ext;
  logic             reflect;

  assign mod_ext = {{(ACC_W-MOD_W){1'b0}}, modulus};
  assign sum     = acc + {{(ACC_W-INC_W){1'b0}}, inc};
  assign reflect = (load_inc != '0) && (load_fwd != dir);

  always_comb begin
    acc_next = acc;
    inc_next = inc;
    dir_next = dir;
    step     = 1'b0;
    if (ctl.do_tick) begin
      // A strictly positive sum issues a step and wraps by the modulus.
      step     = (sum != '0) && !sum[ACC_W-1];
      acc_next = step ? (sum - mod_ext) : sum;
    end else if (ctl.do_line_load) begin
      inc_next = load_inc;
      if (reflect) begin
        dir_next = load_fwd;
        acc_next = '0 - (mod_ext + acc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inc <= '0;
      acc <= '0;
      dir <= 1'b0;
    end else begin
      inc <= inc_next;
      acc <= acc_next;
      dir <= dir_next;
    end
  end

endmodule

>>> hw/rtl/multi_axis_dda_step_generator.sv
// A request is accepted into the input register, and its result is then written into the
// result register, from which it is offered on m_tdata.
// Throughput: one request per cycle; the per-axis accumulate, compare and modulus
// subtract sit between the input and result registers. A held result stalls the input.
// Reset (rst, synchronous): empties both register stages and clears the tick downcount, the
// modulus, and every axis increment, accumulator and direction.
module multi_axis_dda_step_generator
  import mdsg_pkg::*;
#(
  parameter int unsigned AXES      = AXES_DEFAULT,
  parameter int unsigned TICK_BITS = TICK_BITS_DEFAULT,
  localparam int unsigned IN_BITS  = TICK_BITS + MOD_W + (INC_W + 1) * AXES,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8
)(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // segment_ticks, ticks_times_substeps, axis increments, axis forward bits, zero pad
  input  logic [IN_W-1:0] s_tdata,
  // action, move_kind
  input  logic [1:0]      s_tuser,
  output logic            m_tvalid,
  input  logic            m_tready,
  // step_mask[2:0], dir_levels[5:3], busy_res[6], load_accepted[7]
  output logic [7:0]      m_tdata
);

  localparam int unsigned MOD_LO = TICK_BITS;
  localparam int unsigned INC_LO = TICK_BITS + MOD_W;
  localparam int unsigned FWD_LO = INC_LO + INC_W * AXES;

  // Input register.
  logic                 in_valid;
  logic                 in_action;
  logic                 in_kind;
  logic [TICK_BITS-1:0] in_ticks;
  logic [MOD_W-1:0]     in_mod;
  logic [INC_W-1:0]     in_inc [AXES];
  logic [AXES-1:0]      in_fwd;

  // Shared state.
  logic [TICK_BITS-1:0] downcount;
  logic [TICK_BITS-1:0] downcount_next;
  logic [MOD_W-1:0]     modulus;
  logic [MOD_W-1:0]     modulus_next;

  // Result register.
  logic                 out_valid;
  logic [MASK_W-1:0]    out_steps;
  logic [MASK_W-1:0]    out_dirs;
  logic                 out_busy;
  logic                 out_loaded;

  logic                 advance;
  logic                 do_load;
  logic                 do_tick;
  mdsg_axis_ctl_t       axis_ctl;
  logic [AXES-1:0]      steps;
  logic [AXES-1:0]      dirs_next;
  logic [MASK_W-1:0]    steps_mask;
  logic [MASK_W-1:0]    dirs_mask;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign do_load  = advance && (in_action == ACTION_LOAD) && (downcount == '0);
  assign do_tick  = advance && (in_action == ACTION_TICK) && (downcount != '0);

  assign axis_ctl.do_tick      = do_tick;
  assign axis_ctl.do_line_load = do_load && (in_kind == KIND_LINE);

  always_comb begin
    downcount_next = downcount;
    modulus_next   = modulus;
    if (do_load) begin
      downcount_next = in_ticks;
      if (in_kind == KIND_LINE) begin
        modulus_next = in_mod;
      end
    end else if (do_tick) begin
      downcount_next = downcount - 1'b1;
    end
  end

  // Each axis gets modulus_next: on a tick it equals the stored modulus, and on a line
  // load it is the new value that the reflection needs.
  for (genvar i = 0; i < AXES; i++) begin : g_axis
    mdsg_axis u_axis (
      .clk      (clk),
      .rst      (rst),
      .ctl      (axis_ctl),
      .modulus  (modulus_next),
      .load_inc (in_inc[i]),
      .load_fwd (in_fwd[i]),
      .step     (steps[i]),
      .dir_next (dirs_next[i])
    );
  end

  // The result masks carry the low axes only and read zero above AXES.
  for (genvar k = 0; k < MASK_W; k++) begin : g_mask
    if (k < AXES) begin : g_used
      assign steps_mask[k] = steps[k];
      assign dirs_mask[k]  = dirs_next[k];
    end else begin : g_unused
      assign steps_mask[k] = 1'b0;
      assign dirs_mask[k]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      downcount <= '0;
      modulus   <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      downcount <= downcount_next;
      modulus   <= modulus_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser[0];
      in_kind   <= s_tuser[1];
      in_ticks  <= s_tdata[TICK_BITS-1:0];
      in_mod    <= s_tdata[MOD_LO +: MOD_W];
      for (int j = 0; j < AXES; j++) begin
        in_inc[j] <= s_tdata[INC_LO + INC_W * j +: INC_W];
      end
      in_fwd    <= s_tdata[FWD_LO +: AXES];
    end
    if (advance) begin
      out_steps  <= steps_mask;
      out_dirs   <= dirs_mask;
      out_busy   <= (downcount_next != '0);
      out_loaded <= do_load;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_loaded, out_busy, out_dirs, out_steps};

  // A request never both loads a segment and issues steps.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_loaded && (out_steps != '0)))
    else $error("result reports a load together with steps");

  // An accepted load sets the downcount to the requested tick count.
  assert property (@(posedge clk) disable iff (rst)
    do_load |=> (downcount == $past(in_ticks)))
    else $error("downcount not set by segment load");

  // A working tick lowers the downcount by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    do_tick |=> (downcount == $past(downcount) - 1'b1))
    else $error("downcount not decremented on tick");

  // Steps appear only in a result whose request was a working tick.
  assert property (@(posedge clk) disable iff (rst)
    (advance && !do_tick) |=> (out_steps == '0))
    else $error("steps issued without a working tick");

endmodule

>>> bench/multi_axis_dda_step_generator_test.sv
module multi_axis_dda_step_generator_test;
  import mdsg_pkg::*;

  localparam int AXES    = AXES_DEFAULT;
  localparam int TICK_W  = TICK_BITS_DEFAULT;
  localparam int IN_BITS = TICK_W + MOD_W + (INC_W + 1) * AXES;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

  localparam int DRAIN_FREE    = 0;
  localparam int DRAIN_RANDOM  = 1;
  localparam int DRAIN_PATTERN = 2;

  typedef struct packed {
    logic                       action;
    logic                       kind;
    logic [TICK_W-1:0]          ticks;
    logic [MOD_W-1:0]           modulus;
    logic [AXES-1:0][INC_W-1:0] inc;
    logic [AXES-1:0]            fwd;
  } seg_req_t;

  // Same bit order as m_tdata.
  typedef struct packed {
    logic              load_accepted;
    logic              busy_res;
    logic [MASK_W-1:0] dir_levels;
    logic [MASK_W-1:0] step_mask;
  } pulse_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [1:0]      s_tuser = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [7:0]      m_tdata;

  multi_axis_dda_step_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stepper state as the block should hold it.
  logic [TICK_W-1:0]          ticks_left = '0;
  logic [MOD_W-1:0]           mod_now = '0;
  logic [AXES-1:0][INC_W-1:0] axis_inc = '0;
  logic [AXES-1:0][ACC_W-1:0] axis_acc = '0;
  logic [AXES-1:0]            axis_dir = '0;

  pulse_t      pending_pulses[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b0;
  int          drain_style = DRAIN_FREE;
  // The stimulus raises hold_asked; the receiver answers by catching up hold_taken.
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned drain_count = 0;

  function automatic pulse_t next_step_pulses(input seg_req_t r);
    pulse_t           p;
    logic [ACC_W-1:0] sum;
    int               a;
    p = '0;
    if (r.action == ACTION_LOAD) begin
      if (ticks_left == 0) begin
        p.load_accepted = 1'b1;
        ticks_left = r.ticks;
        if (r.kind == KIND_LINE) begin
          mod_now = r.modulus;
          for (a = 0; a < AXES; a++) begin
            axis_inc[a] = r.inc[a];
            // A reversal mirrors the accumulator around the modulus.
            if (r.inc[a] != 0 && r.fwd[a] != axis_dir[a]) begin
              axis_dir[a] = r.fwd[a];
              sum = {2'b00, mod_now} + axis_acc[a];
              axis_acc[a] = '0 - sum;
            end
          end
        end
      end
    end else if (ticks_left != 0) begin
      for (a = 0; a < AXES; a++) begin
        sum = axis_acc[a] + {2'b00, axis_inc[a]};
        if (sum != 0 && !sum[ACC_W-1]) begin
          p.step_mask[a] = 1'b1;
          sum = sum - {2'b00, mod_now};
        end
        axis_acc[a] = sum;
      end
      ticks_left = ticks_left - 1'b1;
    end
    p.dir_levels = axis_dir;
    p.busy_res = (ticks_left != 0);
    return p;
  endfunction

  function automatic logic [IN_W-1:0] pack_segment(input seg_req_t r);
    logic [IN_W-1:0] d;
    int              a;
    d = '0;
    d[TICK_W-1:0] = r.ticks;
    d[TICK_W +: MOD_W] = r.modulus;
    for (a = 0; a < AXES; a++) begin
      d[TICK_W + MOD_W + a * INC_W +: INC_W] = r.inc[a];
      d[TICK_W + MOD_W + AXES * INC_W + a] = r.fwd[a];
    end
    return d;
  endfunction

  function automatic seg_req_t random_load(input logic [TICK_W-1:0] max_ticks);
    seg_req_t r;
    int       a;
    r.action = ACTION_LOAD;
    r.kind = 1'($urandom_range(0, 1));
    r.ticks = TICK_W'($urandom_range(0, max_ticks));
    r.modulus = MOD_W'($urandom);
    for (a = 0; a < AXES; a++) r.inc[a] = INC_W'($urandom);
    r.fwd = AXES'($urandom);
    return r;
  endfunction

  function automatic seg_req_t tick_req();
    seg_req_t r;
    r = random_load({TICK_W{1'b1}});
    r.action = ACTION_TICK;
    return r;
  endfunction

  function automatic seg_req_t line_req(input logic [TICK_W-1:0] t, input logic [MOD_W-1:0] m,
                                        input logic [INC_W-1:0] i0, input logic [INC_W-1:0] i1,
                                        input logic [INC_W-1:0] i2, input logic [AXES-1:0] f);
    seg_req_t r;
    r.action = ACTION_LOAD;
    r.kind = KIND_LINE;
    r.ticks = t;
    r.modulus = m;
    r.inc[0] = i0;
    r.inc[1] = i1;
    r.inc[2] = i2;
    r.fwd = f;
    return r;
  endfunction

  function automatic seg_req_t dwell_req(input logic [TICK_W-1:0] t);
    seg_req_t r;
    r = random_load(t);
    r.kind = KIND_DWELL;
    r.ticks = t;
    return r;
  endfunction

  task automatic send_request(input seg_req_t r);
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {r.kind, r.action};
    s_tdata <= pack_segment(r);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_pulses.push_back(next_step_pulses(r));
    if (burst_left != 0) burst_left--;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_request(tick_req());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pulses.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    pulse_t got;
    pulse_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_pulses.size() == 0) begin
        report_mismatch("result with no request outstanding", 32'(got), 0);
      end else begin
        want = pending_pulses.pop_front();
        if (got.step_mask != want.step_mask)
          report_mismatch("step_mask", 32'(got.step_mask), 32'(want.step_mask));
        if (got.dir_levels != want.dir_levels)
          report_mismatch("dir_levels", 32'(got.dir_levels), 32'(want.dir_levels));
        if (got.busy_res != want.busy_res)
          report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.load_accepted != want.load_accepted)
          report_mismatch("load_accepted", 32'(got.load_accepted),
                          32'(want.load_accepted));
      end
    end
  end

  // Result side: a long hold-off on request, otherwise the selected stall style.
  always @(posedge clk) begin
    drain_count <= drain_count + 1;
    if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left <= 300;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      case (drain_style)
        DRAIN_FREE:   m_tready <= 1'b1;
        DRAIN_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
        default:      m_tready <= ((drain_count % 7) < 4);
      endcase
    end
  end

  task automatic test_idle_requests();
    send_request(tick_req());
    // Zero-length line still latches directions and mirrors accumulators.
    send_request(line_req(0, 7, 3, 0, 9, 3'b101));
    send_request(tick_req());
    send_request(dwell_req(0));
  endtask

  task automatic test_line_extremes();
    send_request(line_req(3, {MOD_W{1'b1}}, {INC_W{1'b1}}, {INC_W{1'b1}}, {INC_W{1'b1}},
                          3'b111));
    send_request(line_req({TICK_W{1'b1}}, {MOD_W{1'b1}}, {INC_W{1'b1}}, {INC_W{1'b1}},
                          {INC_W{1'b1}}, 3'b000));
    run_ticks(4);
    // Axis 2 is idle here, so its direction must not follow the request.
    send_request(line_req(2, 1, {INC_W{1'b1}}, 1, 0, 3'b000));
    run_ticks(2);
  endtask

  task automatic test_zero_modulus_wrap();
    // With no modulus to subtract the accumulators run past the sign bit and wrap.
    send_request(line_req(6, 0, {INC_W{1'b1}}, 1, {INC_W{1'b1}}, 3'b011));
    run_ticks(6);
  endtask

  task automatic test_dwell();
    gaps_on = 1'b1;
    drain_style <= DRAIN_RANDOM;
    send_request(dwell_req(3));
    send_request(line_req(5, 11, 4, 4, 4, 3'b010));
    run_ticks(4);
  endtask

  task automatic test_random_segments(input int unsigned budget);
    int unsigned sent;
    int unsigned scale;
    seg_req_t    r;
    int          a;
    sent = 0;
    while (sent < budget) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      drain_style <= int'($urandom_range(DRAIN_FREE, DRAIN_PATTERN));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) != 0) r = tick_req();
          else r = random_load(40);
          send_request(r);
          sent++;
        end
      end else begin
        if ($urandom_range(0, 6) == 0) begin
          r = dwell_req(TICK_W'($urandom_range(1, 16)));
        end else begin
          r = line_req(0, 0, 0, 0, 0, AXES'($urandom));
          r.ticks = ($urandom_range(0, 19) == 0) ? '0 : TICK_W'($urandom_range(1, 24));
          scale = $urandom_range(1, 50);
          r.modulus = (r.ticks != 0) ? MOD_W'(r.ticks * scale) : MOD_W'(scale);
          if ($urandom_range(0, 7) == 0) r.modulus = MOD_W'($urandom);
          else if ($urandom_range(0, 19) == 0) r.modulus = '0;
          for (a = 0; a < AXES; a++) begin
            if ($urandom_range(0, 4) == 0) r.inc[a] = '0;
            else if ($urandom_range(0, 9) == 0 || r.modulus == 0) r.inc[a] = INC_W'($urandom);
            else r.inc[a] = INC_W'($urandom_range(1, r.modulus));
          end
        end
        send_request(r);
        sent++;
        while (ticks_left != 0 && sent < budget) begin
          if ($urandom_range(0, 9) == 0) send_request(random_load({TICK_W{1'b1}}));
          else send_request(tick_req());
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    drain_style <= DRAIN_FREE;
    hold_asked <= hold_asked + 1;
    send_request(line_req(12, 60, 5, 17, 59, 3'b110));
    run_ticks(8);
    send_request(line_req(4, 9, 1, 2, 3, 3'b001));
    run_ticks(6);
    wait_drained();
  endtask

  task automatic test_long_segment();
    drain_style <= DRAIN_PATTERN;
    send_request(line_req({TICK_W{1'b1}}, 1000, 333, 999, 1, 3'b101));
    run_ticks(10);
    send_request(random_load({TICK_W{1'b1}}));
    run_ticks(10);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_requests();
    test_line_extremes();
    test_zero_modulus_wrap();
    test_dwell();
    wait_drained();
    test_random_segments(470);
    wait_drained();
    test_backpressure();
    test_long_segment();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
